// File: hw/rtl/dvenum_pkg.sv
package dvenum_pkg;

  // width of the number and divisor fields
  localparam int NUM_W = 13;
  // bits of the number that take part in the search (2..13)
  localparam int NUMBER_WIDTH = 13;
  // most results ever given for one number
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W = $clog2(MAX_RESULTS);
  // one restoring step per bit of the dividend
  localparam int STEP_W = $clog2(NUM_W);

  localparam logic [NUM_W-1:0] NUM_MASK = NUM_W'((1 << NUMBER_WIDTH) - 1);

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [NUM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_sts_t;

endpackage

// File: hw/rtl/dvenum_ifs.sv
interface dvenum_in_if;
  logic                         valid;
  logic                         ready;
  logic [dvenum_pkg::NUM_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

interface dvenum_out_if;
  logic                         valid;
  logic                         ready;
  logic [dvenum_pkg::NUM_W-1:0] divisor;
  logic                         last_divisor;
  logic                         invalid_input;

  modport source (output valid, output divisor, output last_divisor, output invalid_input,
                  input ready);
  modport sink (input valid, input divisor, input last_divisor, input invalid_input,
                output ready);
endinterface

// File: hw/rtl/dvenum_div.sv
// bit-serial restoring remainder, one dividend bit per cycle
module dvenum_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dvenum_pkg::div_req_t req,
  output dvenum_pkg::div_sts_t sts
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [dvenum_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [dvenum_pkg::NUM_W-1:0]      dvd_r, dvd_nxt;
  logic [dvenum_pkg::NUM_W-1:0]      dvs_r, dvs_nxt;
  logic [dvenum_pkg::NUM_W-1:0]      rem_r, rem_nxt;
  logic [dvenum_pkg::NUM_W:0]        rem_sh;
  logic [dvenum_pkg::NUM_W:0]        rem_sub;

  assign rem_sh  = {rem_r, dvd_r[dvenum_pkg::NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[dvenum_pkg::NUM_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sub[dvenum_pkg::NUM_W-1:0];
      end else begin
        rem_nxt = rem_sh[dvenum_pkg::NUM_W-1:0];
      end
      step_nxt = step_r + 1'b1;
      if (step_r == dvenum_pkg::STEP_W'(dvenum_pkg::NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    dvd_r  <= dvd_nxt;
    dvs_r  <= dvs_nxt;
    rem_r  <= rem_nxt;
  end

  assign sts.done     = done_r;
  assign sts.rem_zero = (rem_r == '0);

endmodule

// File: hw/rtl/divisor_enumerator.sv
// channel   | dir | payload                                   | transfer when
// ----------+-----+-------------------------------------------+----------------------
// in_chan   | in  | number[12:0]                              | valid && ready
// out_chan  | out | divisor[12:0], last_divisor, invalid_input | valid && ready
//
// each candidate passes the test state, one remainder step per dividend bit and a
// result check; up to half the number candidates are tested, so the largest inputs
// search longest; the serial remainder unit sets the time spent on each candidate
// in_chan.ready is high only while idle; the output register holds one result
// and lets the next number start while the final result still waits
// a stalled output holds the search in its emit state until the slot frees up
// rst_n is synchronous, active low; no state is kept between numbers
module divisor_enumerator (
  input  logic                clk,
  input  logic                rst_n,
  dvenum_in_if.sink           in_chan,
  dvenum_out_if.source        out_chan
);

  // one-hot sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TEST = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [dvenum_pkg::NUM_W-1:0]     num_r, num_nxt;
  logic [dvenum_pkg::NUM_W-1:0]     cand_r, cand_nxt;
  logic [dvenum_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;

  // result waiting to enter the output register
  logic [dvenum_pkg::NUM_W-1:0]     pend_div_r, pend_div_nxt;
  logic                             pend_last_r, pend_last_nxt;
  logic                             pend_inval_r, pend_inval_nxt;

  // output register
  logic                             out_valid_r, out_valid_nxt;
  logic [dvenum_pkg::NUM_W-1:0]     out_div_r, out_div_nxt;
  logic                             out_last_r, out_last_nxt;
  logic                             out_inval_r, out_inval_nxt;

  dvenum_pkg::div_req_t             div_req;
  dvenum_pkg::div_sts_t             div_sts;

  logic [dvenum_pkg::NUM_W-1:0]     in_num;
  logic                             in_xfer;
  logic                             out_free;
  logic                             test_stop;

  assign in_num   = in_chan.number & dvenum_pkg::NUM_MASK;
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  // search ends past half the number, or when only the number's own slot is left
  assign test_stop = (cand_r > (num_r >> 1)) ||
                     (cnt_r == dvenum_pkg::CNT_W'(dvenum_pkg::MAX_RESULTS - 1));

  // single remainder unit: number mod candidate
  assign div_req.start    = (state_r == S_TEST) && !test_stop;
  assign div_req.dividend = num_r;
  assign div_req.divisor  = cand_r;

  dvenum_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .sts   (div_sts)
  );

  always_comb begin
    state_nxt      = state_r;
    num_nxt        = num_r;
    cand_nxt       = cand_r;
    cnt_nxt        = cnt_r;
    pend_div_nxt   = pend_div_r;
    pend_last_nxt  = pend_last_r;
    pend_inval_nxt = pend_inval_r;
    out_valid_nxt  = out_valid_r;
    out_div_nxt    = out_div_r;
    out_last_nxt   = out_last_r;
    out_inval_nxt  = out_inval_r;

    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          num_nxt  = in_num;
          cand_nxt = dvenum_pkg::NUM_W'(1);
          cnt_nxt  = '0;
          if (in_num == '0) begin
            // zero input: single flagged result
            pend_div_nxt   = '0;
            pend_last_nxt  = 1'b1;
            pend_inval_nxt = 1'b1;
            state_nxt      = S_EMIT;
          end else begin
            state_nxt = S_TEST;
          end
        end
      end
      S_TEST: begin
        if (test_stop) begin
          // the number itself closes the list
          pend_div_nxt   = num_r;
          pend_last_nxt  = 1'b1;
          pend_inval_nxt = 1'b0;
          state_nxt      = S_EMIT;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          if (div_sts.rem_zero) begin
            pend_div_nxt   = cand_r;
            pend_last_nxt  = 1'b0;
            pend_inval_nxt = 1'b0;
            state_nxt      = S_EMIT;
          end else begin
            cand_nxt  = cand_r + 1'b1;
            state_nxt = S_TEST;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_div_nxt   = pend_div_r;
          out_last_nxt  = pend_last_r;
          out_inval_nxt = pend_inval_r;
          if (pend_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            cand_nxt  = cand_r + 1'b1;
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_TEST;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    num_r        <= num_nxt;
    cand_r       <= cand_nxt;
    cnt_r        <= cnt_nxt;
    pend_div_r   <= pend_div_nxt;
    pend_last_r  <= pend_last_nxt;
    pend_inval_r <= pend_inval_nxt;
    out_div_r    <= out_div_nxt;
    out_last_r   <= out_last_nxt;
    out_inval_r  <= out_inval_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.divisor       = out_div_r;
  assign out_chan.last_divisor  = out_last_r;
  assign out_chan.invalid_input = out_inval_r;

`ifndef SYNTHESIS
  // remainder unit finishes only while the sequencer waits on it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == S_DIV))
    else $error("remainder done outside divide state");

  // candidates under test stay nonzero and within half the number
  a_cand_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> ((cand_r != '0) && (cand_r <= (num_r >> 1))))
    else $error("candidate out of range");

  // a flagged result is always the single closing zero
  a_invalid_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_inval_r) |-> (out_last_r && (out_div_r == '0)))
    else $error("malformed invalid result");

  // a held result does not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |=> (out_valid_r && $stable(out_div_r)
                                          && $stable(out_last_r)))
    else $error("stalled result changed");
`endif

endmodule

// File: tb/divisor_enumerator_tb.sv
module divisor_enumerator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any transfer before the run is called hung; a prime near
  // the top of the range searches ~4k candidates between two results
  localparam int IDLE_LIMIT = 300_000;
  // receiver hold-off long enough to back up the input side
  localparam int HOLD_OFF_CYCLES = 400;
  // quiet cycles after the last result to catch anything extra
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_NUMBERS = 76;
  localparam int BURST_NUMBERS = 8;

  // one divisor result as seen on the output channel
  typedef struct packed {
    logic [dvenum_pkg::NUM_W-1:0] divisor;
    logic                         last_divisor;
    logic                         invalid_input;
  } divisor_res_t;

  // expected divisor lists, oldest first, checked against each output transfer
  class divisor_scoreboard;
    divisor_res_t divisors_q[$];
    int           errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return divisors_q.size();
    endfunction

    // trial division of an accepted number into its ascending divisor list
    function void note_number(logic [dvenum_pkg::NUM_W-1:0] raw);
      logic [dvenum_pkg::NUM_W-1:0] num;
      int                           half;
      int                           found;
      divisor_res_t                 res;
      num = raw & dvenum_pkg::NUM_MASK;
      if (num == '0) begin
        // zero has no divisors: one flagged result
        res = '{divisor: '0, last_divisor: 1'b1, invalid_input: 1'b1};
        divisors_q.push_back(res);
        return;
      end
      half = int'(num) / 2;
      found = 0;
      for (int cand = 1; cand <= half; cand++) begin
        // room is always kept for the number itself
        if (found >= dvenum_pkg::MAX_RESULTS - 1) break;
        if (int'(num) % cand == 0) begin
          res = '{divisor: dvenum_pkg::NUM_W'(cand), last_divisor: 1'b0,
                  invalid_input: 1'b0};
          divisors_q.push_back(res);
          found++;
        end
      end
      res = '{divisor: num, last_divisor: 1'b1, invalid_input: 1'b0};
      divisors_q.push_back(res);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(divisor_res_t got);
      divisor_res_t want;
      if (divisors_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result divisor=%0d last=%0b invalid=%0b",
                                  got.divisor, got.last_divisor, got.invalid_input));
        return;
      end
      want = divisors_q.pop_front();
      if (got.divisor !== want.divisor)
        report_mismatch($sformatf("divisor got %0d want %0d", got.divisor, want.divisor));
      if (got.last_divisor !== want.last_divisor)
        report_mismatch($sformatf("last_divisor got %0b want %0b (divisor %0d)",
                                  got.last_divisor, want.last_divisor, want.divisor));
      if (got.invalid_input !== want.invalid_input)
        report_mismatch($sformatf("invalid_input got %0b want %0b (divisor %0d)",
                                  got.invalid_input, want.invalid_input, want.divisor));
    endtask
  endclass

  logic clk;
  logic rst_n;

  dvenum_in_if  in_chan_if ();
  dvenum_out_if out_chan_if ();

  divisor_enumerator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan_if),
    .out_chan (out_chan_if)
  );

  divisor_scoreboard sb = new();

  // set by the sender, picked up by the receiver at its next result
  bit hold_off_req;
  // stretches where a side does not idle at all
  bit send_tight;
  bit recv_tight;
  int idle_cycles = 0;

  // edges of the range, single bits set, alternating bit patterns, primes, squares,
  // the number with the most divisors (64 results) and zero twice
  logic [dvenum_pkg::NUM_W-1:0] directed_nums [16] = '{
    13'd0, 13'd1, 13'd2, 13'd3, 13'd4, 13'd6, 13'd36, 13'd97,
    13'd360, 13'd1024, 13'd2730, 13'd5461, 13'd4096, 13'd7560, 13'd8191, 13'd0
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap drawn per item, with runs of back-to-back transfers
  function automatic int draw_gap(ref bit tight);
    if ($urandom_range(0, 9) == 0) tight = !tight;
    return tight ? 0 : $urandom_range(0, 17);
  endfunction

  // mostly small numbers keep the search short; a few reach the top
  function automatic logic [dvenum_pkg::NUM_W-1:0] pick_number();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return '0;
    if (sel < 75) return dvenum_pkg::NUM_W'($urandom_range(1, 255));
    if (sel < 90) return dvenum_pkg::NUM_W'($urandom_range(256, 1023));
    if (sel < 97) return dvenum_pkg::NUM_W'($urandom_range(1024, 2047));
    return dvenum_pkg::NUM_W'($urandom_range(2048, (1 << dvenum_pkg::NUM_W) - 1));
  endfunction

  // offer one number and wait for its transfer; valid stays high on exit
  task automatic send_number(input logic [dvenum_pkg::NUM_W-1:0] num, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : draw_gap(send_tight);
    if (gap > 0) begin
      in_chan_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan_if.valid  <= 1'b1;
    in_chan_if.number <= num;
    @(posedge clk);
    while (!in_chan_if.ready) @(posedge clk);
    sb.note_number(num);
  endtask

  // receiver: ready low for the drawn gap, then high until one transfer
  initial begin
    int gap;
    out_chan_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap(recv_tight);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = HOLD_OFF_CYCLES;
      end
      if (gap > 0) begin
        out_chan_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan_if.valid) @(posedge clk);
    end
  end

  // check every output transfer against the oldest expected divisor
  always @(posedge clk) begin
    if (rst_n && out_chan_if.valid && out_chan_if.ready)
      sb.check_result('{divisor: out_chan_if.divisor,
                        last_divisor: out_chan_if.last_divisor,
                        invalid_input: out_chan_if.invalid_input});
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_chan_if.valid && in_chan_if.ready) || (out_chan_if.valid && out_chan_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    hold_off_req = 1'b0;
    send_tight = 1'b0;
    recv_tight = 1'b0;
    rst_n <= 1'b0;
    in_chan_if.valid  <= 1'b0;
    in_chan_if.number <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed numbers
    foreach (directed_nums[i]) send_number(directed_nums[i], 1'b0);

    // receiver holds off while small numbers keep coming back to back,
    // so the output slot fills and the input side stalls
    hold_off_req = 1'b1;
    for (int i = 0; i < BURST_NUMBERS; i++)
      send_number(dvenum_pkg::NUM_W'($urandom_range(1, 40)), 1'b1);

    // sender goes quiet until every expected divisor has come out
    in_chan_if.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (sb.pending() != 0);

    // random numbers
    for (int i = 0; i < RANDOM_NUMBERS; i++) send_number(pick_number(), 1'b0);
    in_chan_if.valid <= 1'b0;

    // drain, then watch for stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
